>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the cipher RTL.
// Every macro samples on clk_i and is off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ARBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ARBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/arbc_pkg.sv
// ---------------------------------------------------------------------------
// arbc_pkg
// Types, constants and round functions of the AND-rotate CBC block cipher.
// ---------------------------------------------------------------------------
`default_nettype none

package arbc_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned BlkWords = 4;
  localparam int unsigned NumKeys  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned KeyCntW  = 4;
  localparam int unsigned RowW     = WordW * BlkWords;

  typedef logic [WordW-1:0] word_t;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_EXPAND = 2'd0,
    KIND_IV     = 2'd1,
    KIND_ENC    = 2'd2,
    KIND_DEC    = 2'd3
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCHED  = 2'd1,
    ST_RUN    = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_sched;
    logic sched_step;
    logic load_iv;
    logic load_work;
    logic round;
    logic finish;
    logic dec;
  } cmd_t;

  // Key schedule start value
  localparam word_t SchedInit [NumKeys] = '{
    64'ha00f3050f2a18c8f, 64'h8268adc2d69397b9,
    64'hcfbbc9437bcd9379, 64'hbe4f3c1f65e2125d,
    64'h8275e501f230b8d5, 64'hf8882200cdb4f256,
    64'hbcf86e0d3dc199bb, 64'hf49868f3bbc76141
  };

  // Rotate left by a fixed amount (1..63)
  function automatic word_t rol64(input word_t a, input int unsigned n);
    return (a << n) | (a >> (WordW - n));
  endfunction

endpackage

`default_nettype wire

>>> hdl/arbc_if.sv
// ---------------------------------------------------------------------------
// arbc_in_if / arbc_out_if
// Valid/ready request channels of the cipher: command in, result block out.
// ---------------------------------------------------------------------------
`default_nettype none

interface arbc_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  arbc_pkg::word_t                 word_0;
  arbc_pkg::word_t                 word_1;
  arbc_pkg::word_t                 word_2;
  arbc_pkg::word_t                 word_3;
  logic [arbc_pkg::KeyCntW-1:0]    key_words;

  modport source (output valid, kind, word_0, word_1, word_2, word_3, key_words,
                  input ready);
  modport sink   (input valid, kind, word_0, word_1, word_2, word_3, key_words,
                  output ready);
endinterface

interface arbc_out_if;
  logic            valid;
  logic            ready;
  arbc_pkg::word_t out_0;
  arbc_pkg::word_t out_1;
  arbc_pkg::word_t out_2;
  arbc_pkg::word_t out_3;

  modport source (output valid, out_0, out_1, out_2, out_3, input ready);
  modport sink   (input valid, out_0, out_1, out_2, out_3, output ready);
endinterface

`default_nettype wire

>>> hdl/arbc_ram.sv
// ---------------------------------------------------------------------------
// arbc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module arbc_ram #(
  parameter int unsigned Width = 256,
  parameter int unsigned Depth = 72
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/arbc_ctrl.sv
// ---------------------------------------------------------------------------
// arbc_ctrl
// Sequencer: decodes requests, counts schedule steps and rounds, drives the
// round key memory addresses and the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module arbc_ctrl #(
  parameter int unsigned Rounds = 72,
  localparam int unsigned RndW  = (Rounds > 1) ? $clog2(Rounds) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_kind_i,
  output      logic            in_ready_o,
  input  wire logic            out_ready_i,
  output      logic            out_valid_o,
  output      arbc_pkg::cmd_t  cmd_o,
  output      logic            ram_we_o,
  output      logic [RndW-1:0] ram_waddr_o,
  output      logic [RndW-1:0] ram_raddr_o
);

  localparam logic [RndW-1:0] LastStep = RndW'(Rounds - 1);

  arbc_pkg::state_e state_q, state_d;
  arbc_pkg::kind_e  kind;
  logic [RndW-1:0]  cnt_q, cnt_d;
  logic             dec_q, dec_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             last;

  assign kind       = arbc_pkg::kind_e'(in_kind_i);
  assign in_ready_o = (state_q == arbc_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (cnt_q == LastStep);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dec_d       = dec_q;
    cmd_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_raddr_o = '0;
    case (state_q)
      arbc_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind)
            arbc_pkg::KIND_EXPAND: begin
              cmd_o.load_sched = 1'b1;
              cnt_d            = '0;
              state_d          = arbc_pkg::ST_SCHED;
            end
            arbc_pkg::KIND_IV: begin
              cmd_o.load_iv = 1'b1;
            end
            arbc_pkg::KIND_ENC: begin
              cmd_o.load_work = 1'b1;
              dec_d           = 1'b0;
              cnt_d           = '0;
              ram_raddr_o     = '0;
              state_d         = arbc_pkg::ST_RUN;
            end
            arbc_pkg::KIND_DEC: begin
              cmd_o.load_work = 1'b1;
              cmd_o.dec       = 1'b1;
              dec_d           = 1'b1;
              cnt_d           = '0;
              ram_raddr_o     = LastStep;
              state_d         = arbc_pkg::ST_RUN;
            end
            default: begin
              state_d = arbc_pkg::ST_IDLE;
            end
          endcase
        end
      end
      arbc_pkg::ST_SCHED: begin
        // One schedule step and one round key row per cycle
        cmd_o.sched_step = 1'b1;
        ram_we_o         = 1'b1;
        if (last) begin
          state_d = arbc_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      arbc_pkg::ST_RUN: begin
        // Apply this round, fetch the key row of the next one
        cmd_o.round = 1'b1;
        cmd_o.dec   = dec_q;
        if (last) begin
          state_d = arbc_pkg::ST_FINISH;
        end else begin
          cnt_d       = cnt_q + 1'b1;
          ram_raddr_o = dec_q ? (LastStep - (cnt_q + 1'b1)) : (cnt_q + 1'b1);
        end
      end
      arbc_pkg::ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          cmd_o.dec    = dec_q;
          state_d      = arbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = arbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on finish, drop once taken
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arbc_pkg::ST_IDLE;
      cnt_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ARBC_ASSERT_IMP(a_cnt_range, state_q != arbc_pkg::ST_IDLE, cnt_q <= LastStep, "step count out of range")
  `ARBC_ASSERT_NXT(a_cipher_start, accept && (kind == arbc_pkg::KIND_ENC || kind == arbc_pkg::KIND_DEC), state_q == arbc_pkg::ST_RUN && cnt_q == '0, "cipher request did not start rounds")
  `ARBC_ASSERT_NXT(a_run_to_finish, state_q == arbc_pkg::ST_RUN && last, state_q == arbc_pkg::ST_FINISH, "last round did not reach finish")
  `ARBC_ASSERT_NXT(a_finish_valid, cmd_o.finish, out_valid_q, "finished block not presented")

endmodule

`default_nettype wire

>>> hdl/arbc_dp.sv
// ---------------------------------------------------------------------------
// arbc_dp
// Datapath: key registers, key schedule register, one shared round unit,
// CBC chain and saved ciphertext, output block register.
// ---------------------------------------------------------------------------
`default_nettype none

module arbc_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire arbc_pkg::cmd_t                  cmd_i,
  input  wire arbc_pkg::word_t                 word_0_i,
  input  wire arbc_pkg::word_t                 word_1_i,
  input  wire arbc_pkg::word_t                 word_2_i,
  input  wire arbc_pkg::word_t                 word_3_i,
  input  wire logic [arbc_pkg::KeyCntW-1:0]    key_words_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [arbc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire arbc_pkg::word_t                 cfg_data_i,
  input  wire logic [arbc_pkg::RowW-1:0]       ram_rdata_i,
  output      logic [arbc_pkg::RowW-1:0]       ram_wdata_o,
  output      arbc_pkg::word_t                 out_0_o,
  output      arbc_pkg::word_t                 out_1_o,
  output      arbc_pkg::word_t                 out_2_o,
  output      arbc_pkg::word_t                 out_3_o
);

  localparam int unsigned NK = arbc_pkg::NumKeys;
  localparam int unsigned NB = arbc_pkg::BlkWords;
  localparam int unsigned WW = arbc_pkg::WordW;

  arbc_pkg::word_t key_q    [NK];
  arbc_pkg::word_t sched_q  [NK];
  arbc_pkg::word_t sched_d  [NK];
  arbc_pkg::word_t sched_ld [NK];
  arbc_pkg::word_t sr       [NK];
  arbc_pkg::word_t chain_q  [NB];
  arbc_pkg::word_t saved_q  [NB];
  arbc_pkg::word_t work_q   [NB];
  arbc_pkg::word_t out_q    [NB];
  arbc_pkg::word_t in_blk   [NB];
  arbc_pkg::word_t rk       [NB];
  arbc_pkg::word_t enc_d    [NB];
  arbc_pkg::word_t dec_d    [NB];
  logic [arbc_pkg::KeyCntW-1:0] kw_sat;

  assign in_blk[0] = word_0_i;
  assign in_blk[1] = word_1_i;
  assign in_blk[2] = word_2_i;
  assign in_blk[3] = word_3_i;

  // Clamp key word count at eight
  assign kw_sat = (key_words_i > arbc_pkg::KeyCntW'(NK)) ? arbc_pkg::KeyCntW'(NK)
                                                        : key_words_i;

  // Schedule start: constants with the first key words mixed in
  always_comb begin
    for (int i = 0; i < NK; i++) begin
      sched_ld[i] = arbc_pkg::SchedInit[i] ^
                    ((arbc_pkg::KeyCntW'(i) < kw_sat) ? key_q[i] : '0);
    end
  end

  // One schedule step; round key row = low half XOR high half
  always_comb begin
    for (int i = 0; i < NK; i++) begin
      sr[i] = sched_q[i];
    end
    sr[0] = sr[0] ^ (~arbc_pkg::rol64(sr[4], 2) & arbc_pkg::rol64(sr[5], 3));
    sr[1] = sr[1] ^ (~sr[5] & arbc_pkg::rol64(sr[4], 6));
    sr[2] = sr[2] ^ (~arbc_pkg::rol64(sr[7], 4) & sr[6]);
    sr[3] = sr[3] ^ (~arbc_pkg::rol64(sr[6], 11) & arbc_pkg::rol64(sr[7], 8));
    sr[4] = sr[4] ^ sr[7];
    sr[5] = sr[5] ^ sr[4];
    sr[6] = sr[6] ^ sr[5];
    sr[7] = sr[7] ^ sr[6];
    for (int j = 0; j < NB; j++) begin
      ram_wdata_o[WW*j +: WW] = sr[j] ^ sr[j+4];
      sched_d[j]              = sr[j+4];
      sched_d[j+4]            = sr[j];
    end
  end

  // Shared round unit, forward and inverse
  always_comb begin
    arbc_pkg::word_t m0, m1, c0, c1, c2, c3;
    for (int j = 0; j < NB; j++) begin
      rk[j] = ram_rdata_i[WW*j +: WW];
    end
    // Forward: mix, add key, swap halves
    m0 = work_q[0] ^ (~arbc_pkg::rol64(work_q[2], 3) & arbc_pkg::rol64(work_q[3], 7));
    m1 = work_q[1] ^ (~work_q[3] & arbc_pkg::rol64(work_q[2], 13));
    enc_d[0] = work_q[2] ^ rk[2];
    enc_d[1] = work_q[3] ^ rk[3];
    enc_d[2] = m0 ^ rk[0];
    enc_d[3] = m1 ^ rk[1];
    // Inverse: swap halves, add key, mix
    c0 = work_q[2] ^ rk[0];
    c1 = work_q[3] ^ rk[1];
    c2 = work_q[0] ^ rk[2];
    c3 = work_q[1] ^ rk[3];
    dec_d[0] = c0 ^ (~arbc_pkg::rol64(c2, 3) & arbc_pkg::rol64(c3, 7));
    dec_d[1] = c1 ^ (~c3 & arbc_pkg::rol64(c2, 13));
    dec_d[2] = c2;
    dec_d[3] = c3;
  end

  // Key registers and chain value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NK; i++) begin
        key_q[i] <= '0;
      end
      for (int j = 0; j < NB; j++) begin
        chain_q[j] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_data_i;
      end
      for (int j = 0; j < NB; j++) begin
        if (cmd_i.load_iv) begin
          chain_q[j] <= in_blk[j];
        end else if (cmd_i.finish) begin
          chain_q[j] <= cmd_i.dec ? saved_q[j] : work_q[j];
        end
      end
    end
  end

  // Schedule, work block, saved ciphertext and output block
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NK; i++) begin
      if (cmd_i.load_sched) begin
        sched_q[i] <= sched_ld[i];
      end else if (cmd_i.sched_step) begin
        sched_q[i] <= sched_d[i];
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (cmd_i.load_work) begin
        work_q[j] <= cmd_i.dec ? in_blk[j] : (in_blk[j] ^ chain_q[j]);
        if (cmd_i.dec) begin
          saved_q[j] <= in_blk[j];
        end
      end else if (cmd_i.round) begin
        work_q[j] <= cmd_i.dec ? dec_d[j] : enc_d[j];
      end
      if (cmd_i.finish) begin
        out_q[j] <= cmd_i.dec ? (work_q[j] ^ chain_q[j]) : work_q[j];
      end
    end
  end

  assign out_0_o = out_q[0];
  assign out_1_o = out_q[1];
  assign out_2_o = out_q[2];
  assign out_3_o = out_q[3];

endmodule

`default_nettype wire

>>> hdl/and_rotate_block_cipher_256_cbc.sv
// ---------------------------------------------------------------------------
// and_rotate_block_cipher_256_cbc
// 256-bit AND-rotate block cipher in CBC mode with an on-chip key schedule.
//
// Requests enter on in_i (valid/ready) with a kind: expand key, load IV,
// encrypt or decrypt. Only encrypt and decrypt return a block on out_o.
// Key words are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Expand key: one schedule step and one round key row written per cycle
//   into the round key RAM.
// Load IV: taken while the block stays idle.
// Encrypt/decrypt: one round per cycle through a single round unit, paced
//   by the one-row read port of the round key RAM. The next request is
//   taken the cycle after the result is loaded into the output register.
// A stalled receiver holds the result; the block may still accept and run
// the next request and waits at its end until the output register frees.
// Reset clears key words, chain value and output valid. Round keys are
// undefined until the first expand key.
// ---------------------------------------------------------------------------
`default_nettype none

module and_rotate_block_cipher_256_cbc #(
  parameter int unsigned ROUNDS = 72
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  arbc_in_if.sink                           in_i,
  arbc_out_if.source                        out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [arbc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire arbc_pkg::word_t              cfg_data_i
);

  localparam int unsigned RndW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  arbc_pkg::cmd_t              cmd;
  logic                        ram_we;
  logic [RndW-1:0]             ram_waddr;
  logic [RndW-1:0]             ram_raddr;
  logic [arbc_pkg::RowW-1:0]   ram_wdata;
  logic [arbc_pkg::RowW-1:0]   ram_rdata;

  // Sequencer
  arbc_ctrl #(
    .Rounds (ROUNDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr)
  );

  // Datapath
  arbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .word_0_i    (in_i.word_0),
    .word_1_i    (in_i.word_1),
    .word_2_i    (in_i.word_2),
    .word_3_i    (in_i.word_3),
    .key_words_i (in_i.key_words),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ram_rdata_i (ram_rdata),
    .ram_wdata_o (ram_wdata),
    .out_0_o     (out_o.out_0),
    .out_1_o     (out_o.out_1),
    .out_2_o     (out_o.out_2),
    .out_3_o     (out_o.out_3)
  );

  // Round key store, one 256-bit row per round
  arbc_ram #(
    .Width (arbc_pkg::RowW),
    .Depth (ROUNDS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

>>> verif/arbc_checker.sv
// ---------------------------------------------------------------------------
// arbc_checker
// Watches the request, result and key-write ports of the CBC block cipher.
// Keeps its own copy of the key words, round keys and chaining value, and
// works out the block that each encrypt or decrypt request must return.
// Compares every returned block word by word against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module arbc_checker
  import arbc_pkg::*;
#(
  parameter int unsigned ROUNDS = 72
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  arbc_in_if                      req_mon,
  arbc_out_if                     res_mon,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire word_t              cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [BlkWords-1:0][WordW-1:0]   block_t;
  typedef logic [2*BlkWords-1:0][WordW-1:0] sched_t;

  word_t  key_word [NumKeys];
  block_t round_key [ROUNDS];
  block_t chain_blk;
  block_t expected_blocks [$];
  block_t req_blk;
  block_t want_blk;
  block_t got_blk;
  int     mismatches;

  // Rotate left through a doubled word
  function automatic word_t rotl(word_t a, int unsigned n);
    logic [2*WordW-1:0] twice;
    twice = {a, a} << n;
    return twice[2*WordW-1 -: WordW];
  endfunction

  // Nonlinear AND-rotate mix of words 0 and 1
  function automatic block_t and_rot_mix(block_t b);
    b[0] = b[0] ^ (~rotl(b[2], 3) & rotl(b[3], 7));
    b[1] = b[1] ^ (~b[3] & rotl(b[2], 13));
    return b;
  endfunction

  // Exchange the pairs (0,1) and (2,3)
  function automatic block_t swap_pairs(block_t b);
    return {b[1], b[0], b[3], b[2]};
  endfunction

  // Run the key schedule and refill every round key row
  function automatic void expand_round_keys(logic [KeyCntW-1:0] kw);
    sched_t      r;
    int unsigned used;
    used = (kw > NumKeys) ? NumKeys : kw;
    for (int i = 0; i < 2 * BlkWords; i++) begin
      r[i] = SchedInit[i] ^ ((i < used) ? key_word[i] : '0);
    end
    for (int k = 0; k < ROUNDS; k++) begin
      r[0] = r[0] ^ (~rotl(r[4], 2) & rotl(r[5], 3));
      r[1] = r[1] ^ (~r[5] & rotl(r[4], 6));
      r[2] = r[2] ^ (~rotl(r[7], 4) & r[6]);
      r[3] = r[3] ^ (~rotl(r[6], 11) & rotl(r[7], 8));
      r[4] = r[4] ^ r[7];
      r[5] = r[5] ^ r[4];
      r[6] = r[6] ^ r[5];
      r[7] = r[7] ^ r[6];
      for (int i = 0; i < BlkWords; i++) begin
        round_key[k][i] = r[i] ^ r[i+BlkWords];
      end
      r = {r[BlkWords-1:0], r[2*BlkWords-1:BlkWords]};
    end
  endfunction

  function automatic block_t encipher(block_t b);
    for (int k = 0; k < ROUNDS; k++) begin
      b = and_rot_mix(b);
      b = b ^ round_key[k];
      b = swap_pairs(b);
    end
    return b;
  endfunction

  function automatic block_t decipher(block_t b);
    for (int k = ROUNDS - 1; k >= 0; k--) begin
      b = swap_pairs(b);
      b = b ^ round_key[k];
      b = and_rot_mix(b);
    end
    return b;
  endfunction

  // Track key writes, check results, then predict the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) begin
        key_word[i] = '0;
      end
      chain_blk = '0;
      expected_blocks.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        key_word[cfg_idx_i] = cfg_data_i;
      end

      if (res_mon.valid && res_mon.ready) begin
        got_blk = {res_mon.out_3, res_mon.out_2, res_mon.out_1, res_mon.out_0};
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result block, got %h", $time, got_blk);
          mismatches++;
        end else begin
          want_blk = expected_blocks.pop_front();
          for (int i = 0; i < BlkWords; i++) begin
            if (got_blk[i] !== want_blk[i]) begin
              $display("%0t: out_%0d expected %h, got %h",
                       $time, i, want_blk[i], got_blk[i]);
              mismatches++;
            end
          end
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        req_blk = {req_mon.word_3, req_mon.word_2, req_mon.word_1, req_mon.word_0};
        case (kind_e'(req_mon.kind))
          KIND_EXPAND: begin
            expand_round_keys(req_mon.key_words);
          end
          KIND_IV: begin
            chain_blk = req_blk;
          end
          KIND_ENC: begin
            chain_blk = encipher(req_blk ^ chain_blk);
            expected_blocks.push_back(chain_blk);
          end
          default: begin
            expected_blocks.push_back(decipher(req_blk) ^ chain_blk);
            chain_blk = req_blk;
          end
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_blocks.size();
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 256-bit AND-rotate CBC block cipher.
// Loads key words while idle, then sends directed requests at the field
// extremes and special key lengths, followed by phases of random requests
// under random source and sink stalls in all but one phase; a checker scores every result.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import arbc_pkg::*;

  localparam int unsigned Rounds       = 72;
  localparam int unsigned IdlePct      = 29;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned PhaseItems   = 150;
  localparam word_t       AltA         = 64'haaaa_aaaa_aaaa_aaaa;
  localparam word_t       AltB         = 64'h5555_5555_5555_5555;

  typedef enum int unsigned {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND,
    FILL_MIXED
  } key_fill_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  word_t              cfg_data;
  bit                 calm;
  int                 fail_count;
  int                 pending;
  int unsigned        stall_cycles;

  arbc_in_if  req_bus ();
  arbc_out_if res_bus ();

  and_rotate_block_cipher_256_cbc #(
    .ROUNDS (Rounds)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_bus),
    .out_o      (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  arbc_checker #(
    .ROUNDS (Rounds)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_bus),
    .res_mon      (res_bus),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result side at random unless in a calm stretch
  always @(negedge clk_i) begin
    res_bus.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("** and_rotate_block_cipher_256_cbc: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Block word with extra weight on all-zero and all-one
  function automatic word_t pick_word();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_req(kind_e kind, word_t w0, word_t w1, word_t w2, word_t w3,
                          logic [KeyCntW-1:0] kw);
    while (!calm && ($urandom_range(99) < IdlePct)) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.kind      <= kind;
    req_bus.word_0    <= w0;
    req_bus.word_1    <= w1;
    req_bus.word_2    <= w2;
    req_bus.word_3    <= w3;
    req_bus.key_words <= kw;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic send_block(kind_e kind, word_t w);
    send_req(kind, w, w, w, w, KeyCntW'($urandom_range(15)));
  endtask

  task automatic send_random_block(kind_e kind);
    send_req(kind, pick_word(), pick_word(), pick_word(), pick_word(),
             KeyCntW'($urandom_range(15)));
  endtask

  task automatic send_expand(logic [KeyCntW-1:0] kw);
    send_req(KIND_EXPAND, pick_word(), pick_word(), pick_word(), pick_word(), kw);
  endtask

  // Mostly cipher traffic, with occasional rekey and IV reload
  task automatic send_random_req();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) begin
      send_expand(KeyCntW'($urandom_range(15)));
    end else if (sel < 13) begin
      send_random_block(KIND_IV);
    end else if (sel < 56) begin
      send_random_block(KIND_ENC);
    end else begin
      send_random_block(KIND_DEC);
    end
  endtask

  // Wait for every result, then let a rekey run out
  task automatic settle();
    req_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all key words on consecutive cycles
  task automatic load_keys(key_fill_e fill);
    for (int i = 0; i < NumKeys; i++) begin
      cfg_we  <= 1'b1;
      cfg_idx <= CfgIdxW'(i);
      case (fill)
        FILL_ZERO: cfg_data <= '0;
        FILL_ONES: cfg_data <= '1;
        FILL_RAND: cfg_data <= {$urandom, $urandom};
        default:   cfg_data <= pick_word();
      endcase
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    calm              = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    res_bus.ready     = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.kind      = KIND_EXPAND;
    req_bus.word_0    = '0;
    req_bus.word_1    = '0;
    req_bus.word_2    = '0;
    req_bus.word_3    = '0;
    req_bus.key_words = '0;

    // Hold reset, then release it
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: all-one key, extreme blocks and key lengths
    load_keys(FILL_ONES);
    send_req(KIND_EXPAND, '1, '1, '1, '1, KeyCntW'(NumKeys));
    send_block(KIND_IV, '0);
    send_block(KIND_ENC, '0);
    send_block(KIND_ENC, '1);
    send_block(KIND_DEC, '1);
    send_block(KIND_DEC, '0);
    send_block(KIND_IV, '1);
    send_block(KIND_ENC, AltA);
    send_block(KIND_DEC, AltB);
    // schedule from the constants alone
    send_expand(KeyCntW'(0));
    send_random_block(KIND_ENC);
    send_random_block(KIND_DEC);
    // key length past eight words is clamped
    send_expand('1);
    send_random_block(KIND_ENC);
    send_expand(KeyCntW'(NumKeys + 1));
    send_random_block(KIND_DEC);
    send_expand(KeyCntW'(1));
    send_block(KIND_ENC, '1);

    // Directed: all-zero key
    settle();
    load_keys(FILL_ZERO);
    send_expand(KeyCntW'(NumKeys));
    send_block(KIND_ENC, '0);
    send_block(KIND_DEC, '0);

    // Directed: random key, half length
    settle();
    load_keys(FILL_RAND);
    send_expand(KeyCntW'(NumKeys / 2));
    send_random_block(KIND_IV);
    send_random_block(KIND_ENC);
    send_random_block(KIND_DEC);

    // Random phases, each under a fresh key; one phase without stalls
    for (int p = 0; p < RandPhases; p++) begin
      settle();
      load_keys(key_fill_e'(p % 4));
      calm = (p == 2);
      send_expand(KeyCntW'($urandom_range(15)));
      send_random_block(KIND_IV);
      repeat (PhaseItems - 2) send_random_req();
    end
    calm = 1'b0;

    // Drain and give the verdict
    req_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** and_rotate_block_cipher_256_cbc: PASSED **");
    end else begin
      $display("** and_rotate_block_cipher_256_cbc: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
